/* src/ncvc_pkg.sv */
package ncvc_pkg;

   // Field widths.
   localparam int COORD_WIDTH     = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int NUM_REGIONS     = 3;
   localparam int REGION_WIDTH    = 2;
   localparam int IDX_WIDTH       = $clog2(NUM_REGIONS);
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
   localparam int SQ_WIDTH        = 2 * COORD_WIDTH;
   localparam int DIST_WIDTH      = SQ_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COORD_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CENTROID0_X = 3'd0,
      CSR_CENTROID0_Y = 3'd1,
      CSR_CENTROID1_X = 3'd2,
      CSR_CENTROID1_Y = 3'd3,
      CSR_CENTROID2_X = 3'd4,
      CSR_CENTROID2_Y = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } centroid_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic                          last_point;
   } req_type;

   typedef struct packed {
      logic [REGION_WIDTH-1:0]       assigned_region;
      logic                          summary_valid;
      logic [REGION_WIDTH-1:0]       least_region;
      logic [COUNT_WIDTH-1:0]        least_count;
      logic signed [COORD_WIDTH-1:0] chosen_x;
      logic signed [COORD_WIDTH-1:0] chosen_y;
   } rsp_type;

   // Squared per-axis distances to every centroid, as held between stages.
   typedef struct packed {
      logic [NUM_REGIONS-1:0][SQ_WIDTH-1:0] sq_x;
      logic [NUM_REGIONS-1:0][SQ_WIDTH-1:0] sq_y;
      logic                                 last_point;
   } sq_stage_type;

endpackage

/* src/ncvc_csr.sv */
module ncvc_csr (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write_en,
   input  logic [ncvc_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [ncvc_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata,
   output ncvc_pkg::centroid_type [ncvc_pkg::NUM_REGIONS-1:0] centroids
);

   ncvc_pkg::centroid_type [ncvc_pkg::NUM_REGIONS-1:0] centroids_ff;
   ncvc_pkg::centroid_type [ncvc_pkg::NUM_REGIONS-1:0] centroids_in;

   // Indexes past the last register leave everything unchanged.
   always_comb begin
      centroids_in = centroids_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ncvc_pkg::CSR_CENTROID0_X: centroids_in[0].x = $signed(csr_wdata);
            ncvc_pkg::CSR_CENTROID0_Y: centroids_in[0].y = $signed(csr_wdata);
            ncvc_pkg::CSR_CENTROID1_X: centroids_in[1].x = $signed(csr_wdata);
            ncvc_pkg::CSR_CENTROID1_Y: centroids_in[1].y = $signed(csr_wdata);
            ncvc_pkg::CSR_CENTROID2_X: centroids_in[2].x = $signed(csr_wdata);
            ncvc_pkg::CSR_CENTROID2_Y: centroids_in[2].y = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centroids_ff <= '0;
      end else begin
         centroids_ff <= centroids_in;
      end
   end

   assign centroids = centroids_ff;

endmodule

/* src/ncvc_sqdist.sv */
module ncvc_sqdist (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_stall,
   input  ncvc_pkg::req_type                                 req_data,
   input  ncvc_pkg::centroid_type [ncvc_pkg::NUM_REGIONS-1:0] centroids,
   output logic                                              sq_valid,
   input  logic                                              sq_ready,
   output ncvc_pkg::sq_stage_type                            sq_data
);

   logic                   a_valid_ff, a_valid_in;
   ncvc_pkg::req_type      a_ff, a_in;
   logic                   b_valid_ff, b_valid_in;
   ncvc_pkg::sq_stage_type b_ff, b_in, b_calc;
   logic                   a_ready, b_ready;

   // A stage takes a new item when it is empty or its item moves on.
   assign b_ready   = !b_valid_ff || sq_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;

   // One signed difference and one square per axis and centroid.
   always_comb begin
      logic signed [ncvc_pkg::DIFF_WIDTH-1:0] dx, dy;
      logic signed [ncvc_pkg::PROD_WIDTH-1:0] px, py;
      b_calc = '0;
      for (int k = 0; k < ncvc_pkg::NUM_REGIONS; k++) begin
         dx = ncvc_pkg::DIFF_WIDTH'(a_ff.point_x) - ncvc_pkg::DIFF_WIDTH'(centroids[k].x);
         dy = ncvc_pkg::DIFF_WIDTH'(a_ff.point_y) - ncvc_pkg::DIFF_WIDTH'(centroids[k].y);
         px = dx * dx;
         py = dy * dy;
         b_calc.sq_x[k] = px[ncvc_pkg::SQ_WIDTH-1:0];
         b_calc.sq_y[k] = py[ncvc_pkg::SQ_WIDTH-1:0];
      end
      b_calc.last_point = a_ff.last_point;
   end

   always_comb begin
      a_valid_in = a_ready ? req_valid : a_valid_ff;
      a_in       = (a_ready && req_valid) ? req_data : a_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_in       = (b_ready && a_valid_ff) ? b_calc : b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign sq_valid = b_valid_ff;
   assign sq_data  = b_ff;

endmodule

/* src/ncvc_vote.sv */
module ncvc_vote (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              sq_valid,
   output logic                                              sq_ready,
   input  ncvc_pkg::sq_stage_type                            sq_data,
   input  ncvc_pkg::centroid_type [ncvc_pkg::NUM_REGIONS-1:0] centroids,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output ncvc_pkg::rsp_type                                 rsp_data
);

   logic                                                     rsp_valid_ff, rsp_valid_in;
   ncvc_pkg::rsp_type                                        rsp_ff, rsp_in;
   logic [ncvc_pkg::NUM_REGIONS-1:0][ncvc_pkg::COUNT_WIDTH-1:0] counts_ff, counts_in;
   logic [ncvc_pkg::NUM_REGIONS-1:0][ncvc_pkg::COUNT_WIDTH-1:0] counts_upd;
   logic [ncvc_pkg::NUM_REGIONS-1:0][ncvc_pkg::DIST_WIDTH-1:0]  dist_sum;
   logic [ncvc_pkg::IDX_WIDTH-1:0]                            best_idx, least_idx;
   logic                                                     out_ready, load;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign sq_ready  = out_ready;
   assign load      = sq_valid && out_ready;

   // Nearest centroid; a strict compare keeps the lowest index on ties.
   always_comb begin
      logic [ncvc_pkg::DIST_WIDTH-1:0] best_d;
      for (int k = 0; k < ncvc_pkg::NUM_REGIONS; k++) begin
         dist_sum[k] = ncvc_pkg::DIST_WIDTH'(sq_data.sq_x[k])
                     + ncvc_pkg::DIST_WIDTH'(sq_data.sq_y[k]);
      end
      best_idx = '0;
      best_d   = dist_sum[0];
      for (int k = 1; k < ncvc_pkg::NUM_REGIONS; k++) begin
         if (dist_sum[k] < best_d) begin
            best_d   = dist_sum[k];
            best_idx = ncvc_pkg::IDX_WIDTH'(k);
         end
      end
   end

   // Saturating vote, then the smallest count after this item's vote.
   always_comb begin
      logic [ncvc_pkg::COUNT_WIDTH-1:0] least_c;
      for (int k = 0; k < ncvc_pkg::NUM_REGIONS; k++) begin
         if ((best_idx == ncvc_pkg::IDX_WIDTH'(k)) && (counts_ff[k] != ncvc_pkg::COUNT_MAX)) begin
            counts_upd[k] = counts_ff[k] + ncvc_pkg::COUNT_WIDTH'(1);
         end else begin
            counts_upd[k] = counts_ff[k];
         end
      end
      least_idx = '0;
      least_c   = counts_upd[0];
      for (int k = 1; k < ncvc_pkg::NUM_REGIONS; k++) begin
         if (counts_upd[k] < least_c) begin
            least_c   = counts_upd[k];
            least_idx = ncvc_pkg::IDX_WIDTH'(k);
         end
      end
   end

   always_comb begin
      counts_in    = counts_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = out_ready ? sq_valid : rsp_valid_ff;
      if (load) begin
         counts_in              = sq_data.last_point ? '0 : counts_upd;
         rsp_in                 = '0;
         rsp_in.assigned_region = ncvc_pkg::REGION_WIDTH'(best_idx)
                                + ncvc_pkg::REGION_WIDTH'(1);
         if (sq_data.last_point) begin
            rsp_in.summary_valid = 1'b1;
            rsp_in.least_region  = ncvc_pkg::REGION_WIDTH'(least_idx)
                                 + ncvc_pkg::REGION_WIDTH'(1);
            rsp_in.least_count   = counts_upd[least_idx];
            rsp_in.chosen_x      = centroids[least_idx].x;
            rsp_in.chosen_y      = centroids[least_idx].y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         counts_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_region_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.assigned_region != '0)
                    && (!rsp_ff.summary_valid || (rsp_ff.least_region != '0)))
      else $error("result carries region number zero");

   a_summary_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.summary_valid) |->
         (rsp_ff.least_region == '0) && (rsp_ff.least_count == '0)
         && (rsp_ff.chosen_x == '0) && (rsp_ff.chosen_y == '0))
      else $error("summary fields set on an item that is not last");

   a_counts_cleared: assert property (@(posedge clock) disable iff (reset)
      (load && sq_data.last_point) |=> (counts_ff == '0))
      else $error("counters not cleared after the last item of a set");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (load && !sq_data.last_point && (counts_ff[0] == ncvc_pkg::COUNT_MAX))
         |=> (counts_ff[0] == ncvc_pkg::COUNT_MAX))
      else $error("region 1 counter wrapped");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

/* src/nearest_centroid_vote_counter.sv */
// Channel   Direction  Payload               Accepted when
// req       in         ncvc_pkg::req_type    req_valid && !req_stall
// rsp       out        ncvc_pkg::rsp_type    rsp_valid && !rsp_stall
// csr       in         index + write data    csr_write_en
//
// One item is taken per cycle while req_stall is low; it passes the input,
// squared-distance and result registers in turn before its result is presented.
// The squares set the first stage; the distance sums, compare and vote set the second.
// Reset is synchronous and active high; it zeroes the centroids, the counters and
// all stage valid bits. A stall on rsp backs up one stage at a time, so empty
// stages still fill while a result waits.
module nearest_centroid_vote_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ncvc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ncvc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_en,
   input  logic [ncvc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ncvc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Centroid coordinates, to be written only while the block is idle; the block does not enforce it.
   ncvc_pkg::centroid_type [ncvc_pkg::NUM_REGIONS-1:0] centroids;

   // Handshake between the squaring stage and the voting stage.
   logic                   sq_valid;
   logic                   sq_ready;
   ncvc_pkg::sq_stage_type sq_data;

   ncvc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .centroids    (centroids)
   );

   // Registers the point, then the squared x and y distances to each centroid.
   ncvc_sqdist u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .centroids (centroids),
      .sq_valid  (sq_valid),
      .sq_ready  (sq_ready),
      .sq_data   (sq_data)
   );

   // Picks the nearest centroid, counts the vote and builds the set summary
   // on an item marked last, then clears the counters.
   ncvc_vote u_vote (
      .clock     (clock),
      .reset     (reset),
      .sq_valid  (sq_valid),
      .sq_ready  (sq_ready),
      .sq_data   (sq_data),
      .centroids (centroids),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
